>>> hw/rtl/lme_pkg.sv
// Shared types, widths and sine table function for the lattice mode energy block.
// No dependencies; every other file of the block imports this package.
package lme_pkg;

    localparam int DATA_W       = 32;
    localparam int COUPLING_W   = 20;
    localparam int MODE_W       = 7;
    localparam int ENERGY_W     = 63;
    localparam int TDATA_IN_W   = 64;
    localparam int TDATA_OUT_W  = 72;
    localparam int OUT_PAD_W    = TDATA_OUT_W - MODE_W - ENERGY_W;

    localparam logic [COUPLING_W-1:0] COUPLING_RESET = 20'd16384;

    localparam int SINE_W       = 18;
    localparam int HALF_W       = 17;
    localparam int PROD_MAC_W   = DATA_W + SINE_W;
    localparam int ACC_W        = 56;
    localparam int ROUND_SHIFT  = 16;
    localparam int MAG_W        = 40;
    localparam int HH_W         = 2 * HALF_W;
    localparam int GAIN_FULL_W  = COUPLING_W + HH_W;
    localparam int GAIN_SHIFT   = 13;
    localparam int GAIN_W       = 40;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int DIG_W        = 8;
    localparam int NDIG         = MAG_W / DIG_W;
    localparam int MUL_A_W      = SQ_W;
    localparam int MUL_B_W      = MAG_W;
    localparam int PART_W       = MUL_A_W + DIG_W;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int SQB_SHIFT    = 25;
    localparam int TERM_SHIFT   = 56;
    localparam int DRAIN_W      = 2;

    localparam logic [ACC_W-1:0]   ROUND_HALF  = ACC_W'(32768);
    localparam logic [DRAIN_W-1:0] DRAIN_LAST  = 2'd2;
    localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_ENERGY,
        ST_EMIT
    } t_top_state;

    typedef enum logic [2:0] {
        EN_IDLE,
        EN_GAIN,
        EN_SQA,
        EN_SQB,
        EN_TERM
    } t_eng_state;

    typedef struct packed {
        logic issue;
        logic first;
        logic site_ok;
    } t_mac_ctl;

    // Signed Q1.16 sine of a phase given as a fraction of a turn in Q32.
    function automatic logic signed [SINE_W-1:0] lme_sine(input logic [63:0] phase);
        logic [1:0]  q;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        q = phase[31:30];
        u = {34'd0, phase[29:0]};
        if (q[0]) begin
            u = 64'h4000_0000 - u;
        end
        x  = (u * PI_HALF_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t  = ((t * x2) >> 30) / 6;
        s  = s - t;
        t  = ((t * x2) >> 30) / 20;
        s  = s + t;
        t  = ((t * x2) >> 30) / 42;
        s  = s - t;
        t  = ((t * x2) >> 30) / 72;
        s  = s + t;
        t  = ((t * x2) >> 30) / 110;
        s  = s - t;
        t  = ((t * x2) >> 30) / 156;
        s  = s + t;
        r  = (s + 64'd8192) >> 14;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return q[1] ? -SINE_W'(r) : SINE_W'(r);
    endfunction

endpackage

>>> hw/rtl/lme_site_mem.sv
// Site store: one synchronous memory each for positions and velocities.
// Depends on lme_pkg for the data width.
module lme_site_mem
    import lme_pkg::*;
#(
    parameter int N_SITES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(N_SITES)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]          i_wr_pos,
    input  logic [DATA_W-1:0]          i_wr_vel,
    input  logic                       i_rd_en,
    input  logic [$clog2(N_SITES)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]          o_rd_pos,
    output logic [DATA_W-1:0]          o_rd_vel
);

    logic [DATA_W-1:0] r_pos_mem [N_SITES];
    logic [DATA_W-1:0] r_vel_mem [N_SITES];
    logic [DATA_W-1:0] r_rd_pos;
    logic [DATA_W-1:0] r_rd_vel;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pos_mem[i_wr_addr] <= i_wr_pos;
            r_vel_mem[i_wr_addr] <= i_wr_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_pos <= r_pos_mem[i_rd_addr];
            r_rd_vel <= r_vel_mem[i_rd_addr];
        end
    end

    assign o_rd_pos = r_rd_pos;
    assign o_rd_vel = r_rd_vel;

endmodule

>>> hw/rtl/lme_mac.sv
// Sine table and the two multiply-accumulate pipelines for the mode projections.
// Depends on lme_pkg for widths, the control struct and the sine function.
module lme_mac
    import lme_pkg::*;
#(
    parameter int N_SITES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_mac_ctl                       i_ctl,
    input  logic [$clog2(2*N_SITES)-1:0]   i_sine_idx,
    input  logic [DATA_W-1:0]              i_pos,
    input  logic [DATA_W-1:0]              i_vel,
    output logic signed [ACC_W-1:0]        o_acc_a,
    output logic signed [ACC_W-1:0]        o_acc_b
);

    logic signed [SINE_W-1:0] w_sine_rom [2*N_SITES];

    for (genvar m = 0; m < 2 * N_SITES; m++) begin : g_rom
        localparam logic [63:0] PHASE = (64'(m) << 32) / (2 * N_SITES);
        assign w_sine_rom[m] = lme_sine(PHASE);
    end

    logic                         r_s1_vld;
    logic                         r_s1_first;
    logic                         r_s1_ok;
    logic signed [SINE_W-1:0]     r_s1_sine;
    logic                         r_s2_vld;
    logic                         r_s2_first;
    logic signed [PROD_MAC_W-1:0] r_prod_a;
    logic signed [PROD_MAC_W-1:0] r_prod_b;
    logic signed [ACC_W-1:0]      r_acc_a;
    logic signed [ACC_W-1:0]      r_acc_b;
    logic signed [DATA_W-1:0]     w_pos;
    logic signed [DATA_W-1:0]     w_vel;

    // Sites beyond the fill count are read as zero.
    assign w_pos = r_s1_ok ? $signed(i_pos) : '0;
    assign w_vel = r_s1_ok ? $signed(i_vel) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_ctl.first;
        r_s1_ok    <= i_ctl.site_ok;
        r_s1_sine  <= w_sine_rom[i_sine_idx];
        r_s2_first <= r_s1_first;
        r_prod_a   <= w_pos * r_s1_sine;
        r_prod_b   <= w_vel * r_s1_sine;
        if (r_s2_vld) begin
            if (r_s2_first) begin
                r_acc_a <= ACC_W'(r_prod_a);
                r_acc_b <= ACC_W'(r_prod_b);
            end else begin
                r_acc_a <= r_acc_a + ACC_W'(r_prod_a);
                r_acc_b <= r_acc_b + ACC_W'(r_prod_b);
            end
        end
    end

    assign o_acc_a = r_acc_a;
    assign o_acc_b = r_acc_b;

endmodule

>>> hw/rtl/lme_mul.sv
// Iterative unsigned multiplier that consumes one byte of the second operand per cycle.
// Depends on lme_pkg for operand and product widths.
module lme_mul
    import lme_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [PROD_W-1:0]  o_product
);

    localparam int CNT_W = $clog2(NDIG + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [PROD_W-1:0]  r_p;
    logic [PART_W-1:0]  w_part;
    logic [PROD_W-1:0]  n_p;

    assign w_part = PART_W'(r_a) * PART_W'(r_b[MUL_B_W-1 -: DIG_W]);
    assign n_p    = (r_p << DIG_W) + PROD_W'(w_part);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(NDIG);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_cnt != '0) begin
            r_b <= r_b << DIG_W;
            r_p <= n_p;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

>>> hw/rtl/lme_energy.sv
// Mode energy sequencer: rounding, coupling gain, the two squares and the final product.
// Depends on lme_pkg and instantiates lme_mul.
module lme_energy
    import lme_pkg::*;
#(
    parameter int N_SITES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [ACC_W-1:0]      i_acc_a,
    input  logic signed [ACC_W-1:0]      i_acc_b,
    input  logic [$clog2(N_SITES+1)-1:0] i_k,
    input  logic [COUPLING_W-1:0]        i_coupling,
    output logic                         o_done,
    output logic [ENERGY_W-1:0]          o_energy
);

    logic [HALF_W-1:0] w_half_rom [N_SITES+1];

    for (genvar m = 0; m <= N_SITES; m++) begin : g_half
        localparam logic [63:0] PHASE = (64'(m) << 32) / (4 * N_SITES);
        logic signed [SINE_W-1:0] w_val;
        assign w_val         = lme_sine(PHASE);
        assign w_half_rom[m] = w_val[HALF_W-1:0];
    end

    t_eng_state r_state;
    t_eng_state n_state;

    logic [ACC_W-1:0]        w_mag_a;
    logic [ACC_W-1:0]        w_mag_b;
    logic [ACC_W-1:0]        w_rnd_a;
    logic [ACC_W-1:0]        w_rnd_b;
    logic [HALF_W-1:0]       w_h;
    logic [HH_W-1:0]         w_hh;
    logic [GAIN_FULL_W-1:0]  w_gain;
    logic [ENERGY_W+1:0]     w_sum;
    logic [MAG_W-1:0]        r_ma;
    logic [MAG_W-1:0]        r_mb;
    logic [HH_W-1:0]         r_hh;
    logic [GAIN_W-1:0]       r_g;
    logic [SQ_W-1:0]         r_sqa;
    logic [SQ_W-SQB_SHIFT-1:0] r_sqb;
    logic [ENERGY_W-1:0]     r_energy;
    logic                    w_mul_start;
    logic [MUL_A_W-1:0]      w_mul_a;
    logic [MUL_B_W-1:0]      w_mul_b;
    logic                    w_mul_done;
    logic [PROD_W-1:0]       w_mul_p;

    assign w_mag_a = i_acc_a[ACC_W-1] ? $unsigned(-i_acc_a) : $unsigned(i_acc_a);
    assign w_mag_b = i_acc_b[ACC_W-1] ? $unsigned(-i_acc_b) : $unsigned(i_acc_b);
    assign w_rnd_a = w_mag_a + ROUND_HALF;
    assign w_rnd_b = w_mag_b + ROUND_HALF;
    assign w_h     = w_half_rom[i_k];
    assign w_hh    = HH_W'(w_h) * HH_W'(w_h);
    assign w_gain  = GAIN_FULL_W'(i_coupling) * GAIN_FULL_W'(r_hh);
    assign w_sum   = (ENERGY_W + 2)'(w_mul_p[PROD_W-1:TERM_SHIFT]) + (ENERGY_W + 2)'(r_sqb);

    lme_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EN_IDLE: begin
                if (i_start) begin
                    n_state = EN_GAIN;
                end
            end
            EN_GAIN: begin
                n_state = EN_SQA;
            end
            EN_SQA: begin
                if (w_mul_done) begin
                    n_state = EN_SQB;
                end
            end
            EN_SQB: begin
                if (w_mul_done) begin
                    n_state = EN_TERM;
                end
            end
            EN_TERM: begin
                if (w_mul_done) begin
                    n_state = EN_IDLE;
                end
            end
            default: begin
                n_state = EN_IDLE;
            end
        endcase
    end

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = MUL_A_W'(r_ma);
        w_mul_b     = r_ma;
        o_done      = 1'b0;
        unique case (r_state)
            EN_GAIN: begin
                w_mul_start = 1'b1;
            end
            EN_SQA: begin
                w_mul_start = w_mul_done;
                w_mul_a     = MUL_A_W'(r_mb);
                w_mul_b     = r_mb;
            end
            EN_SQB: begin
                w_mul_start = w_mul_done;
                w_mul_a     = r_sqa;
                w_mul_b     = r_g;
            end
            EN_TERM: begin
                o_done = w_mul_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            EN_IDLE: begin
                if (i_start) begin
                    r_ma <= w_rnd_a[ROUND_SHIFT+MAG_W-1:ROUND_SHIFT];
                    r_mb <= w_rnd_b[ROUND_SHIFT+MAG_W-1:ROUND_SHIFT];
                    r_hh <= w_hh;
                end
            end
            EN_GAIN: begin
                r_g <= w_gain[GAIN_SHIFT+GAIN_W-1:GAIN_SHIFT];
            end
            EN_SQA: begin
                if (w_mul_done) begin
                    r_sqa <= w_mul_p[SQ_W-1:0];
                end
            end
            EN_SQB: begin
                if (w_mul_done) begin
                    r_sqb <= w_mul_p[SQ_W-1:SQB_SHIFT];
                end
            end
            EN_TERM: begin
                if (w_mul_done) begin
                    r_energy <= (|w_sum[ENERGY_W+1:ENERGY_W]) ? '1 : w_sum[ENERGY_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_energy = r_energy;

endmodule

>>> hw/rtl/lattice_mode_energy.sv
// Top level of the lattice mode energy block: stream ports, frame control and output register.
// Depends on lme_pkg and instantiates lme_site_mem, lme_mac and lme_energy.
//
// Sites stream in one transaction per cycle until a transaction with tlast set closes the
// frame; sites beyond N_SITES are dropped, and sites a frame did not load count as zero.
// The frame end then starts N_SITES mode computations, each running these steps in order:
// one store read per site through the two MAC pipelines, the pipeline drain, the coupling
// gain, three byte-serial multiplications (operand load and five byte steps each) for the
// squared projections and the gain-weighted term, and the load of the output register, which
// waits while the output is stalled. No site is accepted while modes are being computed.
// The coupling register is written through i_cfg_wr_en and i_cfg_wr_data and
// should only change between frames.
module lattice_mode_energy
    import lme_pkg::*;
#(
    parameter int N_SITES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [COUPLING_W-1:0]  i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] position, [63:32] velocity
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [6:0] mode_number, [69:7] mode_energy, [71:70] zero
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam int AW = $clog2(N_SITES);
    localparam int CW = $clog2(N_SITES + 1);
    localparam int KW = $clog2(N_SITES + 1);
    localparam int IW = $clog2(2 * N_SITES);

    t_top_state r_state;
    t_top_state n_state;

    logic [COUPLING_W-1:0] r_coupling;
    logic [CW-1:0]         r_count;
    logic [KW-1:0]         r_k;
    logic [AW-1:0]         r_site;
    logic [IW-1:0]         r_idx;
    logic [DRAIN_W-1:0]    r_wait;
    logic                  r_ovalid;
    logic [KW-1:0]         r_onum;
    logic [ENERGY_W-1:0]   r_oenergy;
    logic                  r_olast;

    logic                  w_accept;
    logic                  w_store_we;
    logic                  w_last_site;
    logic                  w_last_mode;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_eng_start;
    logic                  w_eng_done;
    logic [ENERGY_W-1:0]   w_energy;
    logic [IW:0]           w_idx_sum;
    logic [IW-1:0]         w_idx_next;
    t_mac_ctl              w_mac_ctl;
    logic [DATA_W-1:0]     w_rd_pos;
    logic [DATA_W-1:0]     w_rd_vel;
    logic signed [ACC_W-1:0] w_acc_a;
    logic signed [ACC_W-1:0] w_acc_b;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_last_site = (r_site == AW'(N_SITES - 1));
    assign w_last_mode = (r_k == KW'(N_SITES));
    assign w_out_free  = !r_ovalid || m_axis_tready;
    assign w_idx_sum   = (IW + 1)'(r_idx) + (IW + 1)'(r_k);
    assign w_idx_next  = (w_idx_sum >= (IW + 1)'(2 * N_SITES))
                       ? IW'(w_idx_sum - (IW + 1)'(2 * N_SITES)) : IW'(w_idx_sum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_last_site) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_wait == DRAIN_LAST) begin
                    n_state = ST_ENERGY;
                end
            end
            ST_ENERGY: begin
                if (w_eng_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = w_last_mode ? ST_LOAD : ST_SWEEP;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        s_axis_tready     = (r_state == ST_LOAD);
        w_store_we        = (r_state == ST_LOAD) && w_accept && (r_count < CW'(N_SITES));
        w_mac_ctl.issue   = (r_state == ST_SWEEP);
        w_mac_ctl.first   = (r_site == '0);
        w_mac_ctl.site_ok = (CW'(r_site) < r_count);
        w_eng_start       = (r_state == ST_DRAIN) && (r_wait == DRAIN_LAST);
        w_out_load        = (r_state == ST_EMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_coupling <= COUPLING_RESET;
            r_count    <= '0;
            r_k        <= KW'(1);
            r_site     <= '0;
            r_idx      <= IW'(1);
            r_wait     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_coupling <= i_cfg_wr_data;
            end
            if (w_store_we) begin
                r_count <= r_count + CW'(1);
            end
            unique case (r_state)
                ST_SWEEP: begin
                    r_site <= w_last_site ? '0 : r_site + AW'(1);
                    r_idx  <= w_idx_next;
                    r_wait <= '0;
                end
                ST_DRAIN: begin
                    r_wait <= r_wait + DRAIN_W'(1);
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_site <= '0;
                        if (w_last_mode) begin
                            r_count <= '0;
                            r_k     <= KW'(1);
                            r_idx   <= IW'(1);
                        end else begin
                            r_k   <= r_k + KW'(1);
                            r_idx <= IW'(r_k) + IW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_onum    <= r_k;
            r_oenergy <= w_energy;
            r_olast   <= w_last_mode;
        end
    end

    lme_site_mem #(
        .N_SITES (N_SITES)
    ) u_site_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_store_we),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_pos  (s_axis_tdata[DATA_W-1:0]),
        .i_wr_vel  (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_rd_en   (w_mac_ctl.issue),
        .i_rd_addr (r_site),
        .o_rd_pos  (w_rd_pos),
        .o_rd_vel  (w_rd_vel)
    );

    lme_mac #(
        .N_SITES (N_SITES)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_sine_idx (r_idx),
        .i_pos      (w_rd_pos),
        .i_vel      (w_rd_vel),
        .o_acc_a    (w_acc_a),
        .o_acc_b    (w_acc_b)
    );

    lme_energy #(
        .N_SITES (N_SITES)
    ) u_energy (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_eng_start),
        .i_acc_a    (w_acc_a),
        .i_acc_b    (w_acc_b),
        .i_k        (r_k),
        .i_coupling (r_coupling),
        .o_done     (w_eng_done),
        .o_energy   (w_energy)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_oenergy, MODE_W'(r_onum)};
    assign m_axis_tlast  = r_olast;

endmodule
